### rtl/pes_pkg.sv
// Shared types, constants and the built-in effect bank of the effect sequencer.
package pes_pkg;

  localparam int NUM_EFFECTS_DEF  = 13;
  localparam int NUM_CHANNELS_DEF = 3;
  localparam int BUILTIN_COUNT    = 13;
  localparam int ENTRY_BYTES      = 16;

  // Kinds of input word.
  typedef enum logic [2:0] {
    KIND_LOAD  = 3'd0,
    KIND_PLAY  = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_TICK  = 3'd3,
    KIND_QUERY = 3'd4
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAY,
    ST_PFIN,
    ST_SIL,
    ST_TICK,
    ST_TAIL,
    ST_STAT
  } state_e;

  // Byte offsets within an effect entry.
  localparam logic [3:0] OFF_NOISE      = 4'd6;
  localparam logic [3:0] OFF_MIXER      = 4'd7;
  localparam logic [3:0] OFF_VOL        = 4'd8;
  localparam logic [3:0] OFF_DELAY      = 4'd11;
  localparam logic [3:0] OFF_STEP_TONE  = 4'd12;
  localparam logic [3:0] OFF_STEP_VOL   = 4'd13;
  localparam logic [3:0] OFF_STEP_NOISE = 4'd14;
  localparam logic [3:0] OFF_DURATION   = 4'd15;

  // Sound chip register numbers.
  localparam logic [3:0] REG_NOISE     = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL       = 4'd8;
  localparam logic [3:0] REG_DELAY     = 4'd11;
  localparam logic [3:0] REG_STEP_TONE = 4'd12;
  localparam logic [3:0] REG_STEP_VOL  = 4'd13;

  // Mixer value that turns every channel off.
  localparam logic [7:0] MIXER_OFF = 8'h3f;

  localparam logic [7:0] DEFAULT_BANK [BUILTIN_COUNT][ENTRY_BYTES] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h3f,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h0f,8'h00,8'h0f,8'h00,8'h0f,8'h00,8'h00,8'h38,
      8'h0f,8'h0f,8'h0f,8'h01,8'h00,8'hff,8'h00,8'h1e},
    '{8'h00,8'h0c,8'h01,8'h0c,8'h02,8'h0c,8'h00,8'h38,
      8'h0f,8'h0f,8'h0f,8'h00,8'h10,8'h00,8'h00,8'h40},
    '{8'h11,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h3e,
      8'h0f,8'h0f,8'h0f,8'h00,8'h14,8'h00,8'h00,8'h10},
    '{8'h40,8'h01,8'h80,8'h01,8'hc0,8'h01,8'h00,8'h38,
      8'h0f,8'h0f,8'h0f,8'h01,8'ha0,8'h00,8'h00,8'h10},
    '{8'hc0,8'h00,8'h00,8'h09,8'h00,8'h07,8'h10,8'h38,
      8'h0f,8'h0f,8'h0f,8'h00,8'h7f,8'h00,8'ha0,8'h0a},
    '{8'hf0,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h36,
      8'h0f,8'h0f,8'h0f,8'h01,8'h08,8'hff,8'h01,8'h1c},
    '{8'h00,8'h10,8'h10,8'h10,8'h20,8'h10,8'h00,8'h38,
      8'h0f,8'h0f,8'h0f,8'h00,8'h04,8'h00,8'h00,8'h90},
    '{8'h00,8'h08,8'h10,8'h08,8'h20,8'h08,8'h00,8'h38,
      8'h0f,8'h0f,8'h0f,8'h00,8'hf0,8'h00,8'h00,8'h80},
    '{8'h00,8'h08,8'h40,8'h08,8'h80,8'h08,8'h00,8'h30,
      8'h0f,8'h0f,8'h0f,8'h00,8'he0,8'h00,8'h04,8'h41},
    '{8'h00,8'h01,8'h00,8'h02,8'h00,8'h03,8'h00,8'h38,
      8'h0f,8'h0f,8'h0f,8'h00,8'hf0,8'h00,8'hff,8'h34},
    '{8'h00,8'h08,8'h10,8'h08,8'h20,8'h08,8'h20,8'h36,
      8'h0f,8'h0f,8'h0f,8'h00,8'h01,8'h00,8'h01,8'h20},
    '{8'h00,8'h08,8'h10,8'h08,8'h20,8'h08,8'h20,8'h36,
      8'h0f,8'h0f,8'h0f,8'h00,8'hff,8'h00,8'hff,8'h20}
  };

  // Byte of the bank as it stands after reset; rows past the built-in ones are zero.
  function automatic logic [7:0] pes_default_byte(input logic [3:0] effect,
                                                  input logic [3:0] offset);
    logic [7:0] result;
    result = 8'h00;
    if ({1'b0, effect} < 5'(BUILTIN_COUNT)) begin
      result = DEFAULT_BANK[effect][offset];
    end
    return result;
  endfunction

endpackage

### rtl/pes_if.sv
// Handshake interfaces for the input words and the result words of the sequencer.
interface pes_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [3:0] effect_index;
  logic [1:0] effect_type;
  logic [3:0] bank_offset;
  logic [7:0] bank_byte;

  modport source (output valid, kind, effect_index, effect_type, bank_offset, bank_byte,
                  input ready);
  modport sink (input valid, kind, effect_index, effect_type, bank_offset, bank_byte,
                output ready);
endinterface

interface pes_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [3:0] reg_address;
  logic [7:0] reg_value;
  logic       playing;
  logic       last;

  modport source (output valid, is_status, reg_address, reg_value, playing, last,
                  input ready);
  modport sink (input valid, is_status, reg_address, reg_value, playing, last,
                output ready);
endinterface

### rtl/pes_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pes_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 208,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write when enabled; the registered read returns the old data on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/psg_effect_sequencer_top.sv
// A load writes the bank when it is accepted; a query is answered with a status word.
// A play reads its 16-byte entry from the bank RAM one byte a cycle, then gives
// four silence words when the effect is muted. An emitting tick gives its 14 words one
// per cycle while the sink is ready; the next word is accepted with the final result.
// The single output register gives one result word per cycle while the sink is ready.
// Reset clears all working state; the bank reads as the built-in effects until loaded.
module psg_effect_sequencer_top #(
  parameter int NUM_EFFECTS  = pes_pkg::NUM_EFFECTS_DEF,
  parameter int NUM_CHANNELS = pes_pkg::NUM_CHANNELS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  pes_in_if.sink       in_i,
  pes_out_if.source    out_o
);
  import pes_pkg::*;

  localparam int DEPTH  = NUM_EFFECTS * ENTRY_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef struct packed {
    logic       valid;
    logic       is_status;
    logic [3:0] reg_address;
    logic [7:0] reg_value;
    logic       playing;
    logic       last;
  } result_t;

  state_e state_q, state_d;

  // Working state of the current effect.
  logic [15:0] tone_q [NUM_CHANNELS];
  logic [15:0] tone_d [NUM_CHANNELS];
  logic [7:0]  vol_q  [NUM_CHANNELS];
  logic [7:0]  vol_d  [NUM_CHANNELS];
  logic [7:0]  noise_q, noise_d;
  logic [7:0]  mixer_q, mixer_d;
  logic [7:0]  reload_q, reload_d;
  logic [7:0]  step_tone_q, step_tone_d;
  logic [7:0]  step_vol_q, step_vol_d;
  logic [7:0]  step_noise_q, step_noise_d;
  logic [7:0]  frames_q, frames_d;
  logic [7:0]  delay_q, delay_d;
  logic        active_q, active_d;
  logic [1:0]  cur_type_q, cur_type_d;

  // Sequencer counters and flags.
  logic            playing_q, playing_d;
  logic [3:0]      play_idx_q, play_idx_d;
  logic [3:0]      rd_cnt_q, rd_cnt_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic [1:0]      sub_q, sub_d;
  logic [2:0]      cnt_q, cnt_d;

  // Bank read path.
  logic              bank_valid_q [DEPTH];
  logic              cap_q;
  logic [3:0]        cap_off_q;
  logic              vld_q;
  logic [7:0]        dflt_q;
  logic [7:0]        ram_rdata;
  logic [7:0]        cap_byte;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        waddr_full;
  logic [7:0]        raddr_full;
  logic              bank_we;

  // Handshake signals.
  result_t emit;
  logic    out_valid_q;
  result_t out_q;
  logic    slot_free;
  logic    push;
  logic    last_push;
  logic    in_acc;
  logic    idx_ok;
  logic    type_match;
  logic    in_ready;

  assign slot_free  = !out_valid_q || out_o.ready;
  assign push       = emit.valid && slot_free;
  assign last_push  = push && emit.last;
  assign in_ready   = (state_q == ST_IDLE) || last_push;
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;
  assign idx_ok     = {1'b0, in_i.effect_index} < 5'(NUM_EFFECTS);
  assign type_match = (in_i.effect_type == 2'd0) || (in_i.effect_type == cur_type_q);

  // Bank memory: loads write at accept, plays read one byte a cycle.
  assign waddr_full = {in_i.effect_index, in_i.bank_offset};
  assign raddr_full = {play_idx_q, rd_cnt_q};
  assign waddr      = waddr_full[ADDR_W-1:0];
  assign raddr      = raddr_full[ADDR_W-1:0];
  assign bank_we    = in_acc && (kind_e'(in_i.kind) == KIND_LOAD) && idx_ok;

  pes_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (bank_we),
    .waddr_i (waddr),
    .wdata_i (in_i.bank_byte),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // A byte never loaded reads as its built-in value.
  assign cap_byte = vld_q ? ram_rdata : dflt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        bank_valid_q[i] <= 1'b0;
      end
    end else if (bank_we) begin
      bank_valid_q[waddr] <= 1'b1;
    end
  end

  // Read side registers travel alongside the RAM read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b0;
    end else begin
      cap_q <= (state_q == ST_PLAY);
    end
  end

  always_ff @(posedge clk_i) begin
    cap_off_q <= rd_cnt_q;
    vld_q     <= bank_valid_q[raddr];
    dflt_q    <= pes_default_byte(play_idx_q, rd_cnt_q);
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_PLAY: if (rd_cnt_q == 4'd15) state_d = ST_PFIN;
      ST_PFIN: state_d = (mixer_q == MIXER_OFF) ? ST_SIL : ST_IDLE;
      ST_SIL:  if (push && (cnt_q == 3'(NUM_CHANNELS))) state_d = ST_IDLE;
      ST_TICK: begin
        if (push && (sub_q == 2'd2) && (ch_q == CH_W'(NUM_CHANNELS - 1))) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: if (push && (cnt_q == 3'd4)) state_d = ST_IDLE;
      ST_STAT: if (push) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (in_acc) begin
      unique case (kind_e'(in_i.kind))
        KIND_PLAY:  if (idx_ok) state_d = ST_PLAY;
        KIND_STOP:  if (type_match) state_d = ST_SIL;
        KIND_TICK: begin
          if (active_q) begin
            if (frames_q == 8'd1) begin
              state_d = ST_SIL;
            end else if (delay_q == 8'd0) begin
              state_d = ST_TICK;
            end
          end
        end
        KIND_QUERY: state_d = ST_STAT;
        default:    ;
      endcase
    end
  end

  // Result word offered in the current state.
  always_comb begin
    emit = '0;
    unique case (state_q)
      ST_SIL: begin
        emit.valid       = 1'b1;
        emit.reg_address = REG_MIXER + {1'b0, cnt_q};
        emit.reg_value   = (cnt_q == 3'd0) ? MIXER_OFF : 8'h00;
        emit.last        = (cnt_q == 3'(NUM_CHANNELS));
      end
      ST_TICK: begin
        emit.valid = 1'b1;
        unique case (sub_q)
          2'd0: begin
            emit.reg_address = 4'({ch_q, 1'b0});
            emit.reg_value   = tone_q[ch_q][7:0];
          end
          2'd1: begin
            emit.reg_address = 4'({ch_q, 1'b1});
            emit.reg_value   = tone_q[ch_q][15:8];
          end
          default: begin
            emit.reg_address = REG_VOL + 4'(ch_q);
            emit.reg_value   = vol_q[ch_q];
          end
        endcase
      end
      ST_TAIL: begin
        emit.valid = 1'b1;
        emit.last  = (cnt_q == 3'd4);
        unique case (cnt_q)
          3'd0: begin
            emit.reg_address = REG_NOISE;
            emit.reg_value   = noise_q;
          end
          3'd1: begin
            emit.reg_address = REG_MIXER;
            emit.reg_value   = mixer_q;
          end
          3'd2: begin
            emit.reg_address = REG_DELAY;
            emit.reg_value   = reload_q;
          end
          3'd3: begin
            emit.reg_address = REG_STEP_TONE;
            emit.reg_value   = step_tone_q;
          end
          default: begin
            emit.reg_address = REG_STEP_VOL;
            emit.reg_value   = step_vol_q;
          end
        endcase
      end
      ST_STAT: begin
        emit.valid     = 1'b1;
        emit.is_status = 1'b1;
        emit.playing   = playing_q;
        emit.last      = 1'b1;
      end
      default: emit = '0;
    endcase
  end

  // Working state update: play capture, emission stepping, then the accepted word.
  always_comb begin
    tone_d       = tone_q;
    vol_d        = vol_q;
    noise_d      = noise_q;
    mixer_d      = mixer_q;
    reload_d     = reload_q;
    step_tone_d  = step_tone_q;
    step_vol_d   = step_vol_q;
    step_noise_d = step_noise_q;
    frames_d     = frames_q;
    delay_d      = delay_q;
    active_d     = active_q;
    cur_type_d   = cur_type_q;
    playing_d    = playing_q;
    play_idx_d   = play_idx_q;
    rd_cnt_d     = rd_cnt_q;
    ch_d         = ch_q;
    sub_d        = sub_q;
    cnt_d        = cnt_q;

    // Bytes of the entry being played land one a cycle.
    if (cap_q) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (cap_off_q == 4'(2 * c)) tone_d[c][7:0] = cap_byte;
        if (cap_off_q == 4'(2 * c + 1)) tone_d[c][15:8] = cap_byte;
        if (cap_off_q == OFF_VOL + 4'(c)) vol_d[c] = cap_byte;
      end
      if (cap_off_q == OFF_NOISE) noise_d = cap_byte;
      if (cap_off_q == OFF_MIXER) mixer_d = cap_byte;
      if (cap_off_q == OFF_DELAY) reload_d = cap_byte;
      if (cap_off_q == OFF_STEP_TONE) step_tone_d = cap_byte;
      if (cap_off_q == OFF_STEP_VOL) step_vol_d = cap_byte;
      if (cap_off_q == OFF_STEP_NOISE) step_noise_d = cap_byte;
      if (cap_off_q == OFF_DURATION) frames_d = cap_byte;
    end

    unique case (state_q)
      ST_PLAY: rd_cnt_d = rd_cnt_q + 4'd1;
      ST_PFIN: begin
        active_d = (mixer_q != MIXER_OFF);
        cnt_d    = 3'd0;
      end
      ST_SIL: if (push) cnt_d = cnt_q + 3'd1;
      ST_TICK: begin
        if (push) begin
          if (sub_q == 2'd2) begin
            // Channel written out: step its tone and volume.
            tone_d[ch_q] = tone_q[ch_q] + {{8{step_tone_q[7]}}, step_tone_q};
            vol_d[ch_q]  = vol_q[ch_q] + step_vol_q;
            sub_d        = 2'd0;
            if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
              cnt_d = 3'd0;
            end else begin
              ch_d = ch_q + CH_W'(1);
            end
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end
      ST_TAIL: begin
        if (push) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd0) noise_d = noise_q + step_noise_q;
        end
      end
      default: ;
    endcase

    if (in_acc) begin
      unique case (kind_e'(in_i.kind))
        KIND_PLAY: begin
          if (idx_ok) begin
            play_idx_d = in_i.effect_index;
            rd_cnt_d   = 4'd0;
            cur_type_d = in_i.effect_type;
            delay_d    = 8'd0;
            active_d   = 1'b0;
          end
        end
        KIND_STOP: begin
          if (type_match) begin
            active_d = 1'b0;
            cnt_d    = 3'd0;
          end
        end
        KIND_TICK: begin
          if (active_q) begin
            frames_d = frames_q - 8'd1;
            if (frames_q == 8'd1) begin
              active_d = 1'b0;
              cnt_d    = 3'd0;
            end else if (delay_q != 8'd0) begin
              delay_d = delay_q - 8'd1;
            end else begin
              delay_d = reload_q;
              ch_d    = '0;
              sub_d   = 2'd0;
            end
          end
        end
        KIND_QUERY: playing_d = active_q && type_match;
        default:    ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        tone_q[c] <= 16'h0000;
        vol_q[c]  <= 8'h00;
      end
      noise_q      <= 8'h00;
      mixer_q      <= 8'h00;
      reload_q     <= 8'h00;
      step_tone_q  <= 8'h00;
      step_vol_q   <= 8'h00;
      step_noise_q <= 8'h00;
      frames_q     <= 8'h00;
      delay_q      <= 8'h00;
      active_q     <= 1'b0;
      cur_type_q   <= 2'd0;
      playing_q    <= 1'b0;
      play_idx_q   <= 4'd0;
      rd_cnt_q     <= 4'd0;
      ch_q         <= '0;
      sub_q        <= 2'd0;
      cnt_q        <= 3'd0;
    end else begin
      state_q      <= state_d;
      tone_q       <= tone_d;
      vol_q        <= vol_d;
      noise_q      <= noise_d;
      mixer_q      <= mixer_d;
      reload_q     <= reload_d;
      step_tone_q  <= step_tone_d;
      step_vol_q   <= step_vol_d;
      step_noise_q <= step_noise_d;
      frames_q     <= frames_d;
      delay_q      <= delay_d;
      active_q     <= active_d;
      cur_type_q   <= cur_type_d;
      playing_q    <= playing_d;
      play_idx_q   <= play_idx_d;
      rd_cnt_q     <= rd_cnt_d;
      ch_q         <= ch_d;
      sub_q        <= sub_d;
      cnt_q        <= cnt_d;
    end
  end

  // Output register: holds a result word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= emit;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.is_status   = out_q.is_status;
  assign out_o.reg_address = out_q.reg_address;
  assign out_o.reg_value   = out_q.reg_value;
  assign out_o.playing     = out_q.playing;
  assign out_o.last        = out_q.last;

endmodule

### dv/tb_psg_effect_sequencer_top.sv
// Self-checking testbench for the effect sequencer: directed table, random play sessions.
module tb_psg_effect_sequencer_top;
  import pes_pkg::*;

  localparam int NUM_FX       = NUM_EFFECTS_DEF;
  localparam int NUM_CH       = NUM_CHANNELS_DEF;
  localparam int RANDOM_WORDS = 250;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 40;

  // Kind codes that the block has no use for.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // How the expected results of a word are obtained.
  typedef enum logic [2:0] {
    ANS_MODEL,
    ANS_NONE,
    ANS_SILENCE,
    ANS_STATUS_OFF,
    ANS_STATUS_ON
  } answer_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] effect_index;
    logic [1:0] effect_type;
    logic [3:0] bank_offset;
    logic [7:0] bank_byte;
  } cmd_word_t;

  typedef struct packed {
    logic       is_status;
    logic [3:0] reg_address;
    logic [7:0] reg_value;
    logic       playing;
    logic       last;
  } chip_word_t;

  typedef struct packed {
    cmd_word_t word;
    answer_e   ans;
  } stim_row_t;

  // Directed words: edge cases of every kind, answers typed in where obvious.
  localparam stim_row_t DIRECTED [27] = '{
    '{'{KIND_QUERY, 4'd0,  2'd0, 4'd0,  8'h00}, ANS_STATUS_OFF},
    '{'{KIND_TICK,  4'd0,  2'd0, 4'd0,  8'h00}, ANS_NONE},
    '{'{KIND_STOP,  4'd0,  2'd0, 4'd0,  8'h00}, ANS_SILENCE},
    '{'{KIND_STOP,  4'd0,  2'd2, 4'd0,  8'h00}, ANS_NONE},
    '{'{KIND_PLAY,  4'd13, 2'd0, 4'd0,  8'h00}, ANS_NONE},
    '{'{KIND_LOAD,  4'd15, 2'd3, 4'd15, 8'hff}, ANS_NONE},
    '{'{KIND_LOAD,  4'd0,  2'd0, 4'd0,  8'hff}, ANS_NONE},
    '{'{KIND_PLAY,  4'd0,  2'd1, 4'd0,  8'h00}, ANS_SILENCE},
    '{'{KIND_QUERY, 4'd0,  2'd0, 4'd0,  8'h00}, ANS_STATUS_OFF},
    '{'{KIND_SPARE_LO, 4'd0, 2'd0, 4'd0, 8'h00}, ANS_NONE},
    '{'{KIND_SPARE_HI, 4'd15, 2'd3, 4'd15, 8'hff}, ANS_NONE},
    '{'{KIND_PLAY,  4'd1,  2'd3, 4'd0,  8'h00}, ANS_NONE},
    '{'{KIND_QUERY, 4'd0,  2'd3, 4'd0,  8'h00}, ANS_STATUS_ON},
    '{'{KIND_QUERY, 4'd0,  2'd2, 4'd0,  8'h00}, ANS_STATUS_OFF},
    '{'{KIND_QUERY, 4'd0,  2'd0, 4'd0,  8'h00}, ANS_STATUS_ON},
    '{'{KIND_TICK,  4'd0,  2'd0, 4'd0,  8'h00}, ANS_MODEL},
    '{'{KIND_TICK,  4'd0,  2'd0, 4'd0,  8'h00}, ANS_MODEL},
    '{'{KIND_TICK,  4'd0,  2'd0, 4'd0,  8'h00}, ANS_MODEL},
    '{'{KIND_STOP,  4'd0,  2'd1, 4'd0,  8'h00}, ANS_NONE},
    '{'{KIND_STOP,  4'd0,  2'd3, 4'd0,  8'h00}, ANS_SILENCE},
    '{'{KIND_LOAD,  4'd12, 2'd0, 4'd15, 8'h01}, ANS_NONE},
    '{'{KIND_LOAD,  4'd12, 2'd0, 4'd12, 8'h80}, ANS_NONE},
    '{'{KIND_PLAY,  4'd12, 2'd2, 4'd0,  8'h00}, ANS_NONE},
    '{'{KIND_TICK,  4'd0,  2'd0, 4'd0,  8'h00}, ANS_SILENCE},
    '{'{KIND_LOAD,  4'd12, 2'd0, 4'd15, 8'h00}, ANS_NONE},
    '{'{KIND_PLAY,  4'd12, 2'd0, 4'd0,  8'h00}, ANS_NONE},
    '{'{KIND_TICK,  4'd0,  2'd0, 4'd0,  8'h00}, ANS_MODEL}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  pes_in_if  in_if ();
  pes_out_if out_if ();

  psg_effect_sequencer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted sequencer state.
  logic [7:0]  bank_mem [NUM_FX][ENTRY_BYTES];
  logic [15:0] tone_q [NUM_CH];
  logic [7:0]  vol_q [NUM_CH];
  logic [7:0]  step_q [3];
  logic [7:0]  noise_q, mixer_q, reload_q, frames_q, delay_q;
  logic        active_q;
  logic [1:0]  cur_type_q;

  chip_word_t  burst_q [$];
  chip_word_t  due_q [$];

  answer_e     offer_ans;
  bit          calm;
  bit          hold_req;
  int          mismatches;
  int          useful_words;
  int          words_checked;
  int          plays_seen, ticks_seen, emit_ticks, queries_seen;

  function automatic void reset_model();
    for (int e = 0; e < NUM_FX; e++) begin
      for (int o = 0; o < ENTRY_BYTES; o++) begin
        bank_mem[e][o] = (e < BUILTIN_COUNT) ? DEFAULT_BANK[e][o] : 8'h00;
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      tone_q[c] = '0;
      vol_q[c]  = '0;
    end
    step_q     = '{8'h00, 8'h00, 8'h00};
    noise_q    = '0;
    mixer_q    = '0;
    reload_q   = '0;
    frames_q   = '0;
    delay_q    = '0;
    active_q   = 1'b0;
    cur_type_q = '0;
  endfunction

  function automatic void add_write(input logic [3:0] addr, input logic [7:0] val);
    burst_q.push_back('{1'b0, addr, val, 1'b0, 1'b0});
  endfunction

  // Mixer off, then every channel volume to zero.
  function automatic void add_silence_words();
    add_write(REG_MIXER, MIXER_OFF);
    for (int c = 0; c < NUM_CH; c++) begin
      add_write(REG_VOL + 4'(c), 8'h00);
    end
  endfunction

  // Advances the predicted state by one accepted word and queues its results.
  function automatic void sequence_word(input cmd_word_t w, input answer_e ans);
    logic hit;
    hit = (w.effect_type == 2'd0) || (w.effect_type == cur_type_q);
    burst_q.delete();
    case (w.kind)
      KIND_LOAD: begin
        if (w.effect_index < NUM_FX) begin
          bank_mem[w.effect_index][w.bank_offset] = w.bank_byte;
        end
      end
      KIND_PLAY: begin
        if (w.effect_index < NUM_FX) begin
          plays_seen++;
          for (int c = 0; c < NUM_CH; c++) begin
            tone_q[c] = {bank_mem[w.effect_index][2 * c + 1], bank_mem[w.effect_index][2 * c]};
            vol_q[c]  = bank_mem[w.effect_index][OFF_VOL + 4'(c)];
          end
          noise_q    = bank_mem[w.effect_index][OFF_NOISE];
          mixer_q    = bank_mem[w.effect_index][OFF_MIXER];
          reload_q   = bank_mem[w.effect_index][OFF_DELAY];
          step_q[0]  = bank_mem[w.effect_index][OFF_STEP_TONE];
          step_q[1]  = bank_mem[w.effect_index][OFF_STEP_VOL];
          step_q[2]  = bank_mem[w.effect_index][OFF_STEP_NOISE];
          frames_q   = bank_mem[w.effect_index][OFF_DURATION];
          cur_type_q = w.effect_type;
          delay_q    = 8'h00;
          active_q   = (mixer_q != MIXER_OFF);
          if (!active_q) begin
            add_silence_words();
          end
        end
      end
      KIND_STOP: begin
        if (hit) begin
          active_q = 1'b0;
          add_silence_words();
        end
      end
      KIND_TICK: begin
        ticks_seen++;
        if (active_q) begin
          frames_q = frames_q - 8'd1;
          if (frames_q == 8'd0) begin
            active_q = 1'b0;
            add_silence_words();
          end else if (delay_q != 8'd0) begin
            delay_q = delay_q - 8'd1;
          end else begin
            emit_ticks++;
            delay_q = reload_q;
            for (int c = 0; c < NUM_CH; c++) begin
              add_write(4'(2 * c), tone_q[c][7:0]);
              add_write(4'(2 * c + 1), tone_q[c][15:8]);
              add_write(REG_VOL + 4'(c), vol_q[c]);
            end
            add_write(REG_NOISE, noise_q);
            add_write(REG_MIXER, mixer_q);
            add_write(REG_DELAY, reload_q);
            add_write(REG_STEP_TONE, step_q[0]);
            add_write(REG_STEP_VOL, step_q[1]);
            // Tone steps are signed bytes widened to the 16-bit period.
            for (int c = 0; c < NUM_CH; c++) begin
              tone_q[c] = tone_q[c] + {{8{step_q[0][7]}}, step_q[0]};
              vol_q[c]  = vol_q[c] + step_q[1];
            end
            noise_q = noise_q + step_q[2];
          end
        end
      end
      KIND_QUERY: begin
        queries_seen++;
        burst_q.push_back('{1'b1, 4'd0, 8'd0, active_q && hit, 1'b0});
      end
      default: begin
      end
    endcase
    // Rows with a typed answer replace what the predictor produced.
    if (ans != ANS_MODEL) begin
      burst_q.delete();
      case (ans)
        ANS_SILENCE:    add_silence_words();
        ANS_STATUS_OFF: burst_q.push_back('{1'b1, 4'd0, 8'd0, 1'b0, 1'b0});
        ANS_STATUS_ON:  burst_q.push_back('{1'b1, 4'd0, 8'd0, 1'b1, 1'b0});
        default: begin
        end
      endcase
    end
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size() - 1].last = 1'b1;
    end
    foreach (burst_q[i]) begin
      due_q.push_back(burst_q[i]);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic cmd_word_t mk_word(input logic [2:0] kind, input logic [3:0] idx,
                                        input logic [1:0] etype, input logic [3:0] off,
                                        input logic [7:0] data);
    return '{kind, idx, etype, off, data};
  endfunction

  // Result words are checked first, then the accepted input word is predicted.
  always @(posedge clk_i) begin : watch_words
    chip_word_t want;
    cmd_word_t  taken;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (due_q.size() == 0) begin
          $error("result word with nothing expected: addr 0x%0h value 0x%0h status %0b",
                 out_if.reg_address, out_if.reg_value, out_if.is_status);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          words_checked++;
          check_field("is_status", 32'(want.is_status), 32'(out_if.is_status));
          check_field("reg_address", 32'(want.reg_address), 32'(out_if.reg_address));
          check_field("reg_value", 32'(want.reg_value), 32'(out_if.reg_value));
          check_field("playing", 32'(want.playing), 32'(out_if.playing));
          check_field("last", 32'(want.last), 32'(out_if.last));
        end
      end
      if (in_if.valid && in_if.ready) begin
        taken = '{in_if.kind, in_if.effect_index, in_if.effect_type, in_if.bank_offset,
                  in_if.bank_byte};
        sequence_word(taken, offer_ans);
      end
    end
  end

  // Sender side: waits its drawn gap, offers the word and holds it until taken.
  task automatic send_word(input cmd_word_t w, input answer_e ans);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.kind         = w.kind;
    in_if.effect_index = w.effect_index;
    in_if.effect_type  = w.effect_type;
    in_if.bank_offset  = w.bank_offset;
    in_if.bank_byte    = w.bank_byte;
    offer_ans          = ans;
    in_if.valid        = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (w.kind <= KIND_QUERY &&
        !((w.kind == KIND_LOAD || w.kind == KIND_PLAY) && w.effect_index >= NUM_FX)) begin
      useful_words++;
    end
  endtask

  // Receiver side: a drawn stall before each word, and one long hold-off on request.
  initial begin : receiver
    int gap;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid && !hold_req);
    end
  end

  initial begin : stimulus
    int  fx;
    int  pick;
    bit  held;
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_LOAD;
    in_if.effect_index = '0;
    in_if.effect_type  = '0;
    in_if.bank_offset  = '0;
    in_if.bank_byte    = '0;
    offer_ans          = ANS_MODEL;
    calm               = 1'b0;
    hold_req           = 1'b0;
    held               = 1'b0;
    mismatches         = 0;
    useful_words       = 0;
    words_checked      = 0;
    plays_seen         = 0;
    ticks_seen         = 0;
    emit_ticks         = 0;
    queries_seen       = 0;
    reset_model();
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].word, DIRECTED[i].ans);
    end

    // Random part: mostly play sessions, half on freshly edited effects, some raw noise.
    while (useful_words < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      if (!held && useful_words > 140) begin
        // Output held off while ticks and queries are offered back to back.
        held     = 1'b1;
        calm     = 1'b1;
        hold_req = 1'b1;
        send_word(mk_word(KIND_PLAY, 4'd1, 2'($urandom), 4'($urandom), 8'($urandom)),
                  ANS_MODEL);
        repeat (6) begin
          send_word(mk_word(KIND_TICK, 4'($urandom), 2'($urandom), 4'($urandom),
                            8'($urandom)), ANS_MODEL);
          send_word(mk_word(KIND_QUERY, 4'($urandom), 2'($urandom), 4'($urandom),
                            8'($urandom)), ANS_MODEL);
        end
      end else if ($urandom_range(0, 9) < 7) begin
        fx = $urandom_range(0, NUM_FX - 1);
        if ($urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(1, 4)) begin
            send_word(mk_word(KIND_LOAD, 4'(fx), 2'($urandom), 4'($urandom_range(0, 15)),
                              8'($urandom)), ANS_MODEL);
          end
          // Short durations let the effect run out on its own.
          if ($urandom_range(0, 2) == 0) begin
            send_word(mk_word(KIND_LOAD, 4'(fx), 2'($urandom), OFF_DURATION,
                              8'($urandom_range(1, 6))), ANS_MODEL);
          end
          if ($urandom_range(0, 5) == 0) begin
            send_word(mk_word(KIND_LOAD, 4'(fx), 2'($urandom), OFF_MIXER, MIXER_OFF),
                      ANS_MODEL);
          end
        end
        send_word(mk_word(KIND_PLAY, 4'(fx), 2'($urandom), 4'($urandom), 8'($urandom)),
                  ANS_MODEL);
        repeat ($urandom_range(2, 10)) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            send_word(mk_word(KIND_TICK, 4'($urandom), 2'($urandom), 4'($urandom),
                              8'($urandom)), ANS_MODEL);
          end else if (pick < 9) begin
            send_word(mk_word(KIND_QUERY, 4'($urandom), 2'($urandom), 4'($urandom),
                              8'($urandom)), ANS_MODEL);
          end else begin
            send_word(mk_word(KIND_STOP, 4'($urandom), 2'($urandom), 4'($urandom),
                              8'($urandom)), ANS_MODEL);
          end
        end
      end else begin
        send_word(mk_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                          2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255))), ANS_MODEL);
      end
    end
    in_if.valid = 1'b0;
    calm        = 1'b0;

    // Drain, then allow for stray words after the last expected one.
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Run covered %0d input words: %0d plays, %0d ticks (%0d emitting), %0d queries.",
             useful_words, plays_seen, ticks_seen, emit_ticks, queries_seen);
    $display("Checked %0d result words, including a %0d-cycle output hold-off.",
             words_checked, LONG_HOLD);
    if (mismatches == 0) begin
      $display("[psg_effect_sequencer_top] OK");
    end else begin
      $display("[psg_effect_sequencer_top] ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("[psg_effect_sequencer_top] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/pes_pkg.sv
rtl/pes_if.sv
rtl/pes_ram.sv
rtl/psg_effect_sequencer_top.sv
dv/tb_psg_effect_sequencer_top.sv
